/* src/i2c_write_master_sequencer_assert.svh */
// Assertion macros shared by the I2C write master sequencer modules.
`ifndef I2C_WRITE_MASTER_SEQUENCER_ASSERT_SVH
`define I2C_WRITE_MASTER_SEQUENCER_ASSERT_SVH

// Implication checked in the same cycle.
`define I2CW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define I2CW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2cw_pkg.sv */
// Types and constants shared by the I2C write master sequencer modules.
package i2cw_pkg;

  localparam int DATA_BITS   = 8;
  localparam int UNIT_WIDTH  = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_SEND  = 2'd3
  } op_t;

  typedef struct packed {
    logic                 is_tick;
    op_t                  op;
    logic [DATA_BITS-1:0] data;
  } item_t;

  typedef struct packed {
    logic rejected;
    logic busy;
    logic sda;
    logic scl;
  } res_t;

endpackage

/* src/i2cw_front.sv */
// Input stage: accepts beats, decodes the opcode and holds one classified item.
module i2cw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    in_data,
  output logic           item_valid,
  input  logic           item_ready,
  output i2cw_pkg::item_t item
);
  import i2cw_pkg::*;

  logic  full;
  item_t held;

  assign in_ready   = !full || item_ready;
  assign item_valid = full;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      held.op      <= op_t'(in_data[1:0]);
      held.is_tick <= (op_t'(in_data[1:0]) == OP_TICK);
      held.data    <= in_data[2 +: DATA_BITS];
    end
  end

endmodule

/* src/i2cw_queue.sv */
// Two-entry queue of classified items between the input stage and the sequencer.
module i2cw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  i2cw_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output i2cw_pkg::item_t pop_item
);
  import i2cw_pkg::*;

  `include "i2c_write_master_sequencer_assert.svh"

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign push_ready = (count != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `I2CW_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNTW'(QUEUE_DEPTH),
    "Queue count exceeds its depth.")
  `I2CW_ASSERT_NEXT(a_pop_drains, clk, rst,
    pop && pop_valid && !push && count == CNTW'(1), !pop_valid,
    "Queue still shows an item after its last one left.")

endmodule

/* src/i2cw_back.sv */
// Sequencer: runs start, stop and send-byte segments, times them, registers results.
module i2cw_back #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [i2cw_pkg::UNIT_WIDTH-1:0]     unit_ticks,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  i2cw_pkg::item_t                     item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output i2cw_pkg::res_t                      res
);
  import i2cw_pkg::*;

  `include "i2c_write_master_sequencer_assert.svh"

  localparam int W  = TICK_COUNTER_WIDTH;
  localparam int CW = (W > UNIT_WIDTH) ? W : UNIT_WIDTH;
  localparam int BW = $clog2(DATA_BITS + 1);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [1:0] units;
  } seg_t;

  logic                 scl, scl_next;
  logic                 sda, sda_next;
  logic                 running, running_next;
  op_t                  kind, kind_next;
  logic [1:0]           phase, phase_next;
  logic [BW-1:0]        bit_idx, bit_idx_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [W-1:0]         tick_count, tick_count_next;
  logic [1:0]           units, units_next;
  logic                 rej_next;
  logic                 pop;
  logic [W-1:0]         tick_inc;
  logic [CW-1:0]        limit;
  logic                 in_unit;
  logic                 last_seg;
  res_t                 res_reg;

  function automatic seg_t seg_levels(op_t k, logic [1:0] ph, logic [BW-1:0] b, logic msb);
    seg_t s;
    s.units = 2'd1;
    unique case (k)
      OP_START: begin
        s.scl = (ph != 2'd2);
        s.sda = (ph == 2'd0);
        s.units = (ph == 2'd0) ? 2'd2 : 2'd1;
      end
      OP_STOP: begin
        s.scl = (ph != 2'd0);
        s.sda = (ph == 2'd2);
        s.units = (ph == 2'd2) ? 2'd2 : 2'd1;
      end
      default: begin
        s.scl = (ph == 2'd1);
        s.sda = (b < BW'(DATA_BITS)) ? msb : 1'b1;
        s.units = (ph == 2'd1) ? 2'd2 : 2'd1;
      end
    endcase
    return s;
  endfunction

  assign pop        = item_valid && item_ready;
  assign item_ready = !res_valid || res_ready;
  assign res        = res_reg;
  assign tick_inc   = tick_count + 1'b1;
  assign limit      = (unit_ticks == '0) ? CW'(1) : CW'(unit_ticks);
  assign in_unit    = (CW'(tick_inc) < limit) && (tick_count != '1);
  assign last_seg   = (phase == 2'd2) && ((kind != OP_SEND) || (bit_idx == BW'(DATA_BITS)));

  always_comb begin
    seg_t seg;
    scl_next        = scl;
    sda_next        = sda;
    running_next    = running;
    kind_next       = kind;
    phase_next      = phase;
    bit_idx_next    = bit_idx;
    shift_next      = shift;
    tick_count_next = tick_count;
    units_next      = units;
    rej_next        = 1'b0;
    seg             = '0;
    if (pop) begin
      if (item.is_tick) begin
        if (running) begin
          if (in_unit) begin
            tick_count_next = tick_inc;
          end else begin
            tick_count_next = '0;
            if (units > 2'd1) begin
              units_next = units - 1'b1;
            end else begin
              units_next = 2'd0;
              if (kind == OP_SEND && phase == 2'd2 && bit_idx < BW'(DATA_BITS)) begin
                shift_next = shift << 1;
              end
              if (last_seg) begin
                running_next = 1'b0;
              end else begin
                if (phase == 2'd2) begin
                  phase_next   = 2'd0;
                  bit_idx_next = bit_idx + 1'b1;
                end else begin
                  phase_next = phase + 1'b1;
                end
                seg        = seg_levels(kind, phase_next, bit_idx_next,
                                        shift_next[DATA_BITS-1]);
                scl_next   = seg.scl;
                sda_next   = seg.sda;
                units_next = seg.units;
              end
            end
          end
        end
      end else if (running) begin
        rej_next = 1'b1;
      end else begin
        kind_next    = item.op;
        phase_next   = 2'd0;
        bit_idx_next = '0;
        if (item.op == OP_SEND) begin
          shift_next = item.data;
        end
        running_next    = 1'b1;
        seg             = seg_levels(item.op, 2'd0, '0, shift_next[DATA_BITS-1]);
        scl_next        = seg.scl;
        sda_next        = seg.sda;
        units_next      = seg.units;
        tick_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl        <= 1'b1;
      sda        <= 1'b1;
      running    <= 1'b0;
      kind       <= OP_TICK;
      phase      <= 2'd0;
      bit_idx    <= '0;
      shift      <= '0;
      tick_count <= '0;
      units      <= 2'd0;
      res_valid  <= 1'b0;
    end else begin
      scl        <= scl_next;
      sda        <= sda_next;
      running    <= running_next;
      kind       <= kind_next;
      phase      <= phase_next;
      bit_idx    <= bit_idx_next;
      shift      <= shift_next;
      tick_count <= tick_count_next;
      units      <= units_next;
      if (pop) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (pop) begin
      res_reg.scl      <= scl_next;
      res_reg.sda      <= sda_next;
      res_reg.busy     <= running_next;
      res_reg.rejected <= rej_next;
    end
  end

  `I2CW_ASSERT_IMPL(a_reject_busy, clk, rst, res_valid && res_reg.rejected, res_reg.busy,
    "A rejected command was reported while the sequencer was idle.")
  `I2CW_ASSERT_IMPL(a_idle_quiet, clk, rst, !running,
    units == 2'd0 && tick_count == '0, "Timer state is left over while idle.")
  `I2CW_ASSERT_NEXT(a_reject_keeps, clk, rst, pop && running && !item.is_tick,
    running && $stable(phase) && $stable(bit_idx) && $stable(tick_count),
    "A rejected command disturbed the running sequence.")

endmodule

/* src/i2c_write_master_sequencer.sv */
// Top level of the write-only I2C master sequencer.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata[1:0] opcode, tdata[9:2] byte_value
//   m_axis   out        tdata[0] scl_level, [1] sda_level, [2] busy_res, [3] rejected
//   cfg      in         cfg_wdata unit_ticks, written when cfg_we is high
//
// One beat is taken per cycle unless the output stalls; each gives one result beat, passing
// the input stage, queue and result register. The sequencer's timer moves once per tick beat.
// Reset drives both bus levels high and clears the input stage, queue and timer.
// A stalled output holds its result while up to three further beats wait inside.
// unit_ticks resets to 500; a value of 0 counts as 1.
module i2c_write_master_sequencer #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // opcode [1:0], byte_value [9:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // scl_level, sda_level, busy_res, rejected
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import i2cw_pkg::*;

  logic [UNIT_WIDTH-1:0] unit_ticks;
  logic                  f_valid;
  logic                  f_ready;
  item_t                 f_item;
  logic                  q_valid;
  logic                  q_pop;
  item_t                 q_item;
  res_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_WIDTH'(500);
    end else if (cfg_we) begin
      unit_ticks <= cfg_wdata;
    end
  end

  i2cw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  i2cw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  i2cw_back #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .unit_ticks (unit_ticks),
    .item_valid (q_valid),
    .item_ready (q_pop),
    .item       (q_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {4'b0000, res};

endmodule

/* verif/i2cw_line_checker.sv */
// Checker that predicts the I2C line levels for every input beat and compares the result beats.
module i2cw_line_checker #(
  parameter int TICK_W = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);
  import i2cw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEND_SEGS = (DATA_BITS + 1) * 3;
  localparam int COND_SEGS = 3;

  logic [UNIT_WIDTH-1:0] unit_len;
  logic                  scl_q;
  logic                  sda_q;
  logic                  run_q;
  op_t                   kind_q;
  logic [4:0]            seg_q;
  logic [DATA_BITS-1:0]  shreg_q;
  logic [TICK_W-1:0]     ticks_q;
  logic [1:0]            units_q;
  res_t                  levels_q[$];
  int                    errs = 0;

  function automatic void load_segment();
    int phase;
    phase   = seg_q % 3;
    units_q = 2'd1;
    case (kind_q)
      OP_START: begin
        scl_q = (seg_q != 5'd2);
        sda_q = (seg_q == 5'd0);
        if (seg_q == 5'd0) units_q = 2'd2;
      end
      OP_STOP: begin
        scl_q = (seg_q != 5'd0);
        sda_q = (seg_q == 5'd2);
        if (seg_q == 5'd2) units_q = 2'd2;
      end
      default: begin
        sda_q = (seg_q / 3 < DATA_BITS) ? shreg_q[DATA_BITS-1] : 1'b1;
        scl_q = (phase == 1);
        if (phase == 1) units_q = 2'd2;
      end
    endcase
    ticks_q = '0;
  endfunction

  function automatic void count_tick();
    logic [TICK_W-1:0] nxt;
    longint unsigned   lim;
    lim = (unit_len == '0) ? 1 : unit_len;
    nxt = ticks_q + 1'b1;
    if (nxt < lim && ticks_q != '1) begin
      ticks_q = nxt;
      return;
    end
    ticks_q = '0;
    if (units_q > 2'd1) begin
      units_q = units_q - 2'd1;
      return;
    end
    units_q = '0;
    if (kind_q == OP_SEND && seg_q % 3 == 2 && seg_q / 3 < DATA_BITS)
      shreg_q = shreg_q << 1;
    if (seg_q + 1 >= ((kind_q == OP_SEND) ? SEND_SEGS : COND_SEGS)) begin
      run_q = 1'b0;
      return;
    end
    seg_q = seg_q + 5'd1;
    load_segment();
  endfunction

  function automatic res_t predict_levels(input op_t op, input logic [DATA_BITS-1:0] val);
    res_t r;
    logic rej;
    rej = 1'b0;
    if (op == OP_TICK) begin
      if (run_q) count_tick();
    end else if (run_q) begin
      rej = 1'b1;
    end else begin
      kind_q = op;
      seg_q  = '0;
      if (op == OP_SEND) shreg_q = val;
      run_q = 1'b1;
      load_segment();
    end
    r.scl      = scl_q;
    r.sda      = sda_q;
    r.busy     = run_q;
    r.rejected = rej;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      unit_len = 16'd500;
      scl_q    = 1'b1;
      sda_q    = 1'b1;
      run_q    = 1'b0;
      kind_q   = OP_TICK;
      seg_q    = '0;
      shreg_q  = '0;
      ticks_q  = '0;
      units_q  = '0;
      levels_q.delete();
    end else begin
      if (cfg_we) unit_len = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        levels_q.push_back(predict_levels(op_t'(s_axis_tdata[1:0]), s_axis_tdata[9:2]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[3:0]);
        if (levels_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %b",
                   $time, got);
          errs++;
        end else begin
          want = levels_q.pop_front();
          check_field("scl_level", want.scl, got.scl);
          check_field("sda_level", want.sda, got.sda);
          check_field("busy_res", want.busy, got.busy);
          check_field("rejected", want.rejected, got.rejected);
        end
      end
    end
    mismatches  <= errs;
    outstanding <= levels_q.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top that drives commands and ticks into the I2C write master and reports the verdict.
module tb_top;
  import i2cw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // opcode [1:0], byte_value [9:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;        // scl_level, sda_level, busy_res, rejected
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cyc = 0;
  int beats_sent = 0;
  int gap_odds = 4;
  int unit_now = 500;
  bit calm = 1'b0;
  bit held_off = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  i2c_write_master_sequencer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  i2cw_line_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("FAIL i2c_write_master_sequencer");
      $finish;
    end
  end

  initial begin
    int r;
    @(posedge clk iff !rst);
    forever begin
      r = $urandom_range(0, 39);
      if (!calm && !held_off && cyc >= 300) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (calm || r == 0) begin
        repeat (50) @(posedge clk);
      end else if (r < 8) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic push_beat(input op_t op, input logic [7:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, val, op};
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    if (beats_sent % 48 == 0)
      gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(3, 8);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic set_unit_ticks(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    unit_now = v;
  endtask

  // A command followed by the ticks that its sequence needs; a cut-short one may leave it running.
  task automatic issue_cmd(input op_t op, input logic [7:0] val, input bit cut_short);
    int span;
    int n;
    span = ((op == OP_SEND) ? 36 : 4) * ((unit_now == 0) ? 1 : unit_now);
    n = cut_short ? $urandom_range(0, span) : span + $urandom_range(0, 2);
    push_beat(op, val);
    repeat (n) begin
      if ($urandom_range(0, 29) == 0)
        push_beat(op_t'($urandom_range(1, 3)), 8'($urandom));
      else
        push_beat(OP_TICK, 8'($urandom));
    end
  endtask

  task automatic run_traffic(input int budget);
    int goal;
    int k;
    goal = beats_sent + budget;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 1));
      end else begin
        issue_cmd(OP_START, 8'($urandom), $urandom_range(0, 9) == 0);
        k = $urandom_range(1, 3);
        repeat (k) issue_cmd(OP_SEND, 8'($urandom), $urandom_range(0, 9) == 0);
        issue_cmd(OP_STOP, 8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    int unit_plan[5];
    unit_plan = '{1, 2, 0, 3, 1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_beat(OP_TICK, 8'hFF);
    push_beat(OP_START, 8'h00);
    repeat (3) push_beat(OP_TICK, 8'h00);
    push_beat(OP_START, 8'hFF);
    push_beat(OP_STOP, 8'h5A);
    push_beat(OP_SEND, 8'hFF);
    push_beat(OP_SEND, 8'h00);
    set_unit_ticks(16'd0);
    repeat (6) push_beat(OP_TICK, 8'($urandom));
    issue_cmd(OP_SEND, 8'hFF, 1'b0);
    issue_cmd(OP_SEND, 8'h00, 1'b0);
    issue_cmd(OP_SEND, 8'hA5, 1'b0);
    issue_cmd(OP_STOP, 8'hFF, 1'b0);

    foreach (unit_plan[i]) begin
      set_unit_ticks(16'(unit_plan[i]));
      run_traffic(80);
    end

    calm = 1'b1;
    set_unit_ticks(16'd1);
    run_traffic(40);
    set_unit_ticks(16'hFFFF);
    push_beat(OP_START, 8'($urandom));
    repeat (40) begin
      if ($urandom_range(0, 7) == 0)
        push_beat(op_t'($urandom_range(1, 3)), 8'($urandom));
      else
        push_beat(OP_TICK, 8'($urandom));
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS i2c_write_master_sequencer");
    else
      $display("FAIL i2c_write_master_sequencer");
    $finish;
  end

endmodule
